>>> hw/rtl/rtpts_pkg.sv
// Package for the RTP timestamp mapper: status codes, register indexes,
// pipeline stage payload types and the constant-divisor step function.
// No dependencies.
`default_nettype none

package rtpts_pkg;

  localparam int unsigned RateW     = 31;
  localparam int unsigned BaseW     = 32;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIdxW   = 2;

  // 1e9 = 2^9 * 1953125: shift off 9 bits, long-divide the rest by the odd factor
  localparam logic [20:0] OddDiv    = 21'd1953125;

  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned Div1Stages    = 9;   // 36 quotient bits
  localparam int unsigned Div2Stages    = 8;   // 32 quotient bits

  // stage numbering: sub, abs, div1 x9, mul, div2 x8, sum, out
  localparam int unsigned StSub    = 0;
  localparam int unsigned StAbs    = 1;
  localparam int unsigned StDiv1   = 2;
  localparam int unsigned StMul    = StDiv1 + Div1Stages;
  localparam int unsigned StDiv2   = StMul + 1;
  localparam int unsigned StSum    = StDiv2 + Div2Stages;
  localparam int unsigned StOut    = StSum + 1;
  localparam int unsigned NumStages = StOut + 1;

  localparam logic [RateW-1:0] ClockRateRst = 31'd90000;

  typedef enum logic [StatusW-1:0] {
    ST_OK          = 3'd0,
    ST_SUB_OVF     = 3'd1,
    ST_RESCALE_OVF = 3'd2,
    ST_PREROLL     = 3'd3,
    ST_EXT_OVF     = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_RATE = 2'd0,
    CFG_BASE_TS    = 2'd1,
    CFG_ORIGIN_NS  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic        ovf;
    logic [63:0] diff;
  } sub_t;

  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [63:0] mag;
  } abs_t;

  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [8:0]  lo;
    logic [20:0] r;
    logic [35:0] qn;   // remaining dividend bits on top, quotient bits shift in below
  } div1_t;

  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [64:0] whole;
    logic [60:0] fprod;
  } mul_t;

  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [64:0] whole;
    logic [20:0] r;
    logic [31:0] qn;
  } div2_t;

  typedef struct packed {
    status_e     status;
    logic        neg;
    logic [63:0] mag;
  } sum_t;

  // one restoring step: shift in a bit, subtract the odd divisor if it fits
  function automatic logic [21:0] div_step(input logic [20:0] r, input logic b);
    logic [21:0] t;
    logic [21:0] s;
    t = {r, b};
    s = t - {1'b0, OddDiv};
    if (t >= {1'b0, OddDiv}) begin
      div_step = {1'b1, s[20:0]};
    end else begin
      div_step = {1'b0, t[20:0]};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rtp_timestamp_mapper_unit.sv
// Top level of the RTP timestamp mapper: a 22-stage pipeline that rescales
// nanosecond presentation times onto the RTP media clock.
// Depends on rtpts_pkg.
//
// Usage: each transaction on the s_axis side carries one signed 64-bit
// presentation time in nanoseconds. Each produces exactly one transaction on
// the m_axis side with a status code, the 64-bit extended timestamp and the
// 32-bit wire timestamp; on any error both timestamps are zero.
// m_axis_tvalid rises once the transaction has passed through all 22 stages;
// the first stage loads at the accepting edge. One transaction is accepted
// every cycle while the receiver does not stall. The depth is set by the two
// constant dividers by 1e9, each retiring four quotient bits per stage.
// Configuration (clock rate, base timestamp, origin) is written through the
// cfg port and takes effect at the next edge; the user must write it only
// while the pipeline is empty, which the block does not enforce. Reset empties
// the pipeline and loads a clock rate of 90000, base 0 and origin 0. When the
// receiver stalls, each stage holds until the next one frees up: bubbles close
// up and s_axis_tready falls only once every stage holds a transaction.
`default_nettype none

module rtp_timestamp_mapper_unit
  import rtpts_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [63:0]        s_axis_tdata_i,   // [63:0] presentation_ns
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // [2:0] status, [66:3] extended_ticks, [98:67] wire_timestamp, [103:99] zero
  output logic [103:0]            m_axis_tdata_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_wdata_i
);

  logic [RateW-1:0] clock_rate_q;
  logic [BaseW-1:0] base_ts_q;
  logic [63:0]      origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_rate_q <= ClockRateRst;
      base_ts_q    <= '0;
      origin_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CLOCK_RATE: clock_rate_q <= cfg_wdata_i[RateW-1:0];
        CFG_BASE_TS:    base_ts_q    <= cfg_wdata_i[BaseW-1:0];
        CFG_ORIGIN_NS:  origin_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its successor loads
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   rdy;

  always_comb begin
    rdy[NumStages] = m_axis_tready_i;
    for (int i = NumStages - 1; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy[0]) begin
        valid_q[0] <= s_axis_tvalid_i;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (rdy[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = valid_q[StOut];

  // ---------------------------------------------------------------------------
  // Subtract origin with signed overflow detection
  sub_t sub_d, sub_q;
  logic [63:0] sub_diff;

  always_comb begin
    sub_diff     = s_axis_tdata_i - origin_q;
    sub_d.diff   = sub_diff;
    sub_d.ovf    = (s_axis_tdata_i[63] ^ origin_q[63]) & (s_axis_tdata_i[63] ^ sub_diff[63]);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StSub]) sub_q <= sub_d;
  end

  // Split sign and magnitude; the negated minimum reads as 2^63 unsigned
  abs_t abs_d, abs_q;

  always_comb begin
    abs_d.ovf = sub_q.ovf;
    abs_d.neg = sub_q.diff[63];
    abs_d.mag = sub_q.diff[63] ? (~sub_q.diff + 64'd1) : sub_q.diff;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StAbs]) abs_q <= abs_d;
  end

  // ---------------------------------------------------------------------------
  // Seconds: (mag >> 9) / 1953125, four bits a stage
  div1_t d1_src [Div1Stages];
  div1_t d1_d   [Div1Stages];
  div1_t d1_q   [Div1Stages];

  always_comb begin
    logic [21:0] st;
    d1_src[0].ovf = abs_q.ovf;
    d1_src[0].neg = abs_q.neg;
    d1_src[0].lo  = abs_q.mag[8:0];
    d1_src[0].r   = {2'b00, abs_q.mag[63:45]};
    d1_src[0].qn  = abs_q.mag[44:9];
    for (int k = 1; k < Div1Stages; k++) begin
      d1_src[k] = d1_q[k-1];
    end
    for (int k = 0; k < Div1Stages; k++) begin
      d1_d[k] = d1_src[k];
      for (int j = 0; j < StepsPerStage; j++) begin
        st         = div_step(d1_d[k].r, d1_d[k].qn[35]);
        d1_d[k].r  = st[20:0];
        d1_d[k].qn = {d1_d[k].qn[34:0], st[21]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Div1Stages; k++) begin
      if (rdy[StDiv1 + k]) d1_q[k] <= d1_d[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Whole ticks and the fractional product
  mul_t        mul_d, mul_q;
  logic [29:0] rem_ns;

  always_comb begin
    rem_ns      = {d1_q[Div1Stages-1].r, d1_q[Div1Stages-1].lo};
    mul_d.ovf   = d1_q[Div1Stages-1].ovf;
    mul_d.neg   = d1_q[Div1Stages-1].neg;
    mul_d.whole = d1_q[Div1Stages-1].qn[33:0] * clock_rate_q;
    mul_d.fprod = rem_ns * clock_rate_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StMul]) mul_q <= mul_d;
  end

  // ---------------------------------------------------------------------------
  // Fractional ticks: (fprod >> 9) / 1953125
  div2_t d2_src [Div2Stages];
  div2_t d2_d   [Div2Stages];
  div2_t d2_q   [Div2Stages];

  always_comb begin
    logic [21:0] st;
    d2_src[0].ovf   = mul_q.ovf;
    d2_src[0].neg   = mul_q.neg;
    d2_src[0].whole = mul_q.whole;
    d2_src[0].r     = {1'b0, mul_q.fprod[60:41]};
    d2_src[0].qn    = mul_q.fprod[40:9];
    for (int k = 1; k < Div2Stages; k++) begin
      d2_src[k] = d2_q[k-1];
    end
    for (int k = 0; k < Div2Stages; k++) begin
      d2_d[k] = d2_src[k];
      for (int j = 0; j < StepsPerStage; j++) begin
        st         = div_step(d2_d[k].r, d2_d[k].qn[31]);
        d2_d[k].r  = st[20:0];
        d2_d[k].qn = {d2_d[k].qn[30:0], st[21]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Div2Stages; k++) begin
      if (rdy[StDiv2 + k]) d2_q[k] <= d2_d[k];
    end
  end

  // ---------------------------------------------------------------------------
  // Tick magnitude and signed range check: +2^63-1 or -2^63
  sum_t        sum_d, sum_q;
  logic [65:0] tick_mag;
  logic        range_ovf;

  always_comb begin
    tick_mag = {1'b0, d2_q[Div2Stages-1].whole} + {34'd0, d2_q[Div2Stages-1].qn};
    if (d2_q[Div2Stages-1].neg) begin
      range_ovf = (tick_mag[65:64] != 2'b00) || (tick_mag[63] && (tick_mag[62:0] != '0));
    end else begin
      range_ovf = (tick_mag[65:63] != 3'b000);
    end
    sum_d.neg = d2_q[Div2Stages-1].neg;
    sum_d.mag = tick_mag[63:0];
    if (d2_q[Div2Stages-1].ovf) begin
      sum_d.status = ST_SUB_OVF;
    end else if (range_ovf) begin
      sum_d.status = ST_RESCALE_OVF;
    end else begin
      sum_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StSum]) sum_q <= sum_d;
  end

  // ---------------------------------------------------------------------------
  // Apply to 2^32 + base and register the result
  logic [63:0] ext_base;
  logic [64:0] ext_add;
  logic [64:0] ext_sub;
  status_e     out_status_d, out_status_q;
  logic [63:0] out_ext_d, out_ext_q;

  always_comb begin
    ext_base     = {31'd0, 1'b1, base_ts_q};
    ext_add      = {1'b0, ext_base} + {1'b0, sum_q.mag};
    ext_sub      = {1'b0, ext_base} - {1'b0, sum_q.mag};
    out_status_d = sum_q.status;
    out_ext_d    = '0;
    if (sum_q.status == ST_OK) begin
      if (sum_q.neg) begin
        if (ext_sub[64]) begin
          out_status_d = ST_PREROLL;
        end else begin
          out_ext_d = ext_sub[63:0];
        end
      end else begin
        if (ext_add[64]) begin
          out_status_d = ST_EXT_OVF;
        end else begin
          out_ext_d = ext_add[63:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[StOut]) begin
      out_status_q <= out_status_d;
      out_ext_q    <= out_ext_d;
    end
  end

  assign m_axis_tdata_o = {5'd0, out_ext_q[31:0], out_ext_q, out_status_q};

endmodule

`default_nettype wire
